// File: src/scaled_glyph_row_renderer_defines.svh
// Assertion macros used by the renderer's checker file.
`ifndef SCALED_GLYPH_ROW_RENDERER_DEFINES_SVH
`define SCALED_GLYPH_ROW_RENDERER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SGR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SGR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/sgr_pkg.sv
// Shared types and constants of the scaled glyph row renderer.
`timescale 1ns / 1ps
package sgr_pkg;

   localparam int NUM_GLYPHS_DEF     = 256;
   localparam int MAX_GLYPH_ROWS_DEF = 32;
   localparam int GLYPH_BITS_DEF     = 32;
   localparam int MAX_SIZE_DEF       = 64;
   localparam int CELL_LIMIT         = 64;
   localparam int MASK_W             = 64;

   localparam logic       BG_TRANSPARENT_RST = 1'b1;
   localparam logic [6:0] TEXT_SIZE_RST      = 7'd8;
   localparam logic [5:0] FONT_HEIGHT_RST    = 6'd8;

   typedef enum logic [1:0] {
      CSR_TEXT_SIZE      = 2'd0,
      CSR_FONT_HEIGHT    = 2'd1,
      CSR_BG_TRANSPARENT = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_LOAD_ROW   = 3'd0,
      OP_LOAD_WIDTH = 3'd1,
      OP_DRAW       = 3'd2,
      OP_SET_CURSOR = 3'd3,
      OP_NEWLINE    = 3'd4
   } op_type;

   typedef struct packed {
      logic [6:0] text_size;
      logic [5:0] font_height;
      logic       bg_transparent;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  char_code;
      logic [4:0]  row_index;
      logic [31:0] row_bits;
      logic [5:0]  glyph_width;
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
   } cmd_type;

endpackage

// File: src/scaled_glyph_row_renderer.sv
// Top level of the scaled glyph row renderer: control registers, front end and back end.
//
//   channel | ports   | moves
//   req     | req_*   | one op item per transfer
//   rsp     | rsp_*   | one destination row per transfer, top row first
//   csr     | csr_*   | one register write per transfer, always ready
//
// Load, cursor and newline ops execute in the back end's S_EXEC; unknown ops are dropped.
// Draw: width table read, serial width divider, cell width, column map over map length
//   (cell or glyph width, up to 64), then a glyph-store read per row (one per destination
//   row scaling up, one per source row scaling down); its single read port sets the pace.
// Reset is synchronous; glyph store and width table hold no reset value.
// A stalled rsp holds the back end; the 2-entry command queue keeps req open until full.
`timescale 1ns / 1ps
module scaled_glyph_row_renderer import sgr_pkg::*; #(
   parameter int NUM_GLYPHS     = NUM_GLYPHS_DEF,
   parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF,
   parameter int GLYPH_BITS     = GLYPH_BITS_DEF,
   parameter int MAX_SIZE       = MAX_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_row_index,
   input  logic [31:0] req_row_bits,
   input  logic [5:0]  req_glyph_width,
   input  logic [15:0] req_cursor_x,
   input  logic [15:0] req_cursor_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_row_y,
   output logic [15:0] rsp_row_x,
   output logic [6:0]  rsp_cell_width,
   output logic [63:0] rsp_fg_mask,
   output logic        rsp_fill_bg,
   output logic        rsp_last_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_TEXT_SIZE:      cfg_in.text_size      = csr_data;
            CSR_FONT_HEIGHT:    cfg_in.font_height    = csr_data[5:0];
            CSR_BG_TRANSPARENT: cfg_in.bg_transparent = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_size      <= TEXT_SIZE_RST;
         cfg_ff.font_height    <= FONT_HEIGHT_RST;
         cfg_ff.bg_transparent <= BG_TRANSPARENT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgr_front #(
      .NUM_GLYPHS (NUM_GLYPHS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_char_code   (req_char_code),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .req_glyph_width (req_glyph_width),
      .req_cursor_x    (req_cursor_x),
      .req_cursor_y    (req_cursor_y),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd)
   );

   sgr_back #(
      .NUM_GLYPHS     (NUM_GLYPHS),
      .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
      .GLYPH_BITS     (GLYPH_BITS),
      .MAX_SIZE       (MAX_SIZE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_y      (rsp_row_y),
      .rsp_row_x      (rsp_row_x),
      .rsp_cell_width (rsp_cell_width),
      .rsp_fg_mask    (rsp_fg_mask),
      .rsp_fill_bg    (rsp_fill_bg),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

// File: src/sgr_front.sv
// Front end: accepts items, drops unknown ops, folds the character code, queues commands.
`timescale 1ns / 1ps
module sgr_front import sgr_pkg::*; #(
   parameter int NUM_GLYPHS = NUM_GLYPHS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_row_index,
   input  logic [31:0] req_row_bits,
   input  logic [5:0]  req_glyph_width,
   input  logic [15:0] req_cursor_x,
   input  logic [15:0] req_cursor_y,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   localparam int CH_RECIP = (1 << 16) / NUM_GLYPHS + 1;

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        keep;
   logic        push;
   logic        pop;
   logic [23:0] ch_prod;
   logic [7:0]  ch_quot;
   logic [15:0] ch_back;
   logic [7:0]  ch_mod;
   cmd_type     cmd_new;

   // char_code mod NUM_GLYPHS by reciprocal, exact for 8-bit codes
   assign ch_prod = 24'(req_char_code) * 24'(CH_RECIP);
   assign ch_quot = ch_prod[23:16];
   assign ch_back = 16'(ch_quot) * 16'(NUM_GLYPHS);
   assign ch_mod  = req_char_code - ch_back[7:0];

   always_comb begin
      case (op_type'(req_op))
         OP_LOAD_ROW, OP_LOAD_WIDTH, OP_DRAW, OP_SET_CURSOR, OP_NEWLINE: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      cmd_new.op          = op_type'(req_op);
      cmd_new.char_code   = ch_mod;
      cmd_new.row_index   = req_row_index;
      cmd_new.row_bits    = req_row_bits;
      cmd_new.glyph_width = req_glyph_width;
      cmd_new.cursor_x    = req_cursor_x;
      cmd_new.cursor_y    = req_cursor_y;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && keep;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: src/sgr_back.sv
// Back end: glyph store, cursor, serial width divider and row sequencer.
`timescale 1ns / 1ps
module sgr_back import sgr_pkg::*; #(
   parameter int NUM_GLYPHS     = NUM_GLYPHS_DEF,
   parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF,
   parameter int GLYPH_BITS     = GLYPH_BITS_DEF,
   parameter int MAX_SIZE       = MAX_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_row_y,
   output logic [15:0] rsp_row_x,
   output logic [6:0]  rsp_cell_width,
   output logic [63:0] rsp_fg_mask,
   output logic        rsp_fill_bg,
   output logic        rsp_last_row
);

   localparam int SIZE_W = $clog2(MAX_SIZE + 1);
   localparam int HGT_W  = $clog2(MAX_GLYPH_ROWS + 1);
   localparam int WID_W  = $clog2(GLYPH_BITS + 1);
   localparam int PROD_W = SIZE_W + WID_W;
   localparam int DCNT_W = $clog2(PROD_W + 1);
   localparam int SX_W   = $clog2(GLYPH_BITS);
   localparam int DX_W   = $clog2(CELL_LIMIT);
   localparam int IDX_W  = (SX_W > DX_W) ? SX_W : DX_W;
   localparam int CNT_W  = $clog2(CELL_LIMIT + 1);
   localparam int RW     = ((SIZE_W > HGT_W) ? SIZE_W : HGT_W) + 1;
   localparam int CH_W   = $clog2(NUM_GLYPHS);
   localparam int DEPTH  = NUM_GLYPHS * MAX_GLYPH_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_WID, S_DIV, S_CELL, S_MAP, S_RD, S_USE
   } state_type;

   // storage
   logic [GLYPH_BITS-1:0] glyph_mem [DEPTH];
   logic [WID_W-1:0]      wtab_mem [NUM_GLYPHS];
   logic [GLYPH_BITS-1:0] glyph_q_ff;
   logic [WID_W-1:0]      wtab_q_ff;
   logic [SX_W-1:0]       umap_ff [CELL_LIMIT];
   logic [DX_W-1:0]       dmap_ff [GLYPH_BITS];

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [WID_W-1:0]      width_ff, width_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [HGT_W-1:0]      rem_ff, rem_in;
   logic [PROD_W-1:0]     quot_ff, quot_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]      cell_ff, cell_in;
   logic [CNT_W-1:0]      map_len_ff, map_len_in;
   logic                  up_ff, up_in;
   logic [CNT_W-1:0]      xcnt_ff, xcnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [HGT_W-1:0]      row_ff, row_in;
   logic [SIZE_W-1:0]     dst_ff, dst_in;
   logic [RW-1:0]         racc_ff, racc_in;
   logic [MASK_W-1:0]     macc_ff, macc_in;
   logic [15:0]           cur_x_ff, cur_x_in;
   logic [15:0]           cur_y_ff, cur_y_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_row_y_ff, rsp_row_y_in;
   logic [15:0]           rsp_row_x_ff, rsp_row_x_in;
   logic [6:0]            rsp_cell_width_ff, rsp_cell_width_in;
   logic [63:0]           rsp_fg_mask_ff, rsp_fg_mask_in;
   logic                  rsp_fill_bg_ff, rsp_fill_bg_in;
   logic                  rsp_last_row_ff, rsp_last_row_in;

   logic                  gm_we, gm_re, wt_we, wt_re, map_we;
   logic [ADDR_W-1:0]     gm_base, gm_waddr, gm_raddr;
   logic [GLYPH_BITS-1:0] gm_wdata;
   logic [WID_W-1:0]      wt_wdata;
   logic [CH_W-1:0]       ch_idx;
   logic [SIZE_W-1:0]     size_eff;
   logic [HGT_W-1:0]      height_eff;
   logic                  out_free;
   logic [HGT_W:0]        rem_sh;
   logic [PROD_W:0]       map_sum;
   logic [PROD_W-1:0]     map_num, map_den;
   logic [RW-1:0]         rsum;
   logic [MASK_W-1:0]     up_mask, scat_mask, new_mask;
   logic                  step, last_src, emit;

   // effective size and height
   always_comb begin
      if (cfg.text_size == 7'd0) begin
         size_eff = SIZE_W'(1);
      end else if (int'(cfg.text_size) > MAX_SIZE) begin
         size_eff = SIZE_W'(MAX_SIZE);
      end else begin
         size_eff = SIZE_W'(cfg.text_size);
      end
      if (cfg.font_height == 6'd0) begin
         height_eff = HGT_W'(1);
      end else if (int'(cfg.font_height) > MAX_GLYPH_ROWS) begin
         height_eff = HGT_W'(MAX_GLYPH_ROWS);
      end else begin
         height_eff = HGT_W'(cfg.font_height);
      end
   end

   assign ch_idx   = cmd_ff.char_code[CH_W-1:0];
   assign gm_base  = ADDR_W'(int'(ch_idx) * MAX_GLYPH_ROWS);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // upscale row: each column picks its source bit
   always_comb begin
      for (int x = 0; x < MASK_W; x++) begin
         up_mask[x] = (x < int'(cell_ff)) && glyph_q_ff[umap_ff[x]];
      end
   end

   // downscale row: each source bit lands on its destination column
   always_comb begin
      scat_mask = '0;
      for (int x = 0; x < GLYPH_BITS; x++) begin
         if ((x < int'(width_ff)) && glyph_q_ff[x]) begin
            scat_mask[dmap_ff[x]] = 1'b1;
         end
      end
   end

   assign new_mask = macc_ff | scat_mask;

   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      width_in          = width_ff;
      prod_in           = prod_ff;
      rem_in            = rem_ff;
      quot_in           = quot_ff;
      dcnt_in           = dcnt_ff;
      cell_in           = cell_ff;
      map_len_in        = map_len_ff;
      up_in             = up_ff;
      xcnt_in           = xcnt_ff;
      idx_in            = idx_ff;
      acc_in            = acc_ff;
      row_in            = row_ff;
      dst_in            = dst_ff;
      racc_in           = racc_ff;
      macc_in           = macc_ff;
      cur_x_in          = cur_x_ff;
      cur_y_in          = cur_y_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_row_y_in      = rsp_row_y_ff;
      rsp_row_x_in      = rsp_row_x_ff;
      rsp_cell_width_in = rsp_cell_width_ff;
      rsp_fg_mask_in    = rsp_fg_mask_ff;
      rsp_fill_bg_in    = rsp_fill_bg_ff;
      rsp_last_row_in   = rsp_last_row_ff;
      cmd_ready         = 1'b0;
      gm_we             = 1'b0;
      gm_re             = 1'b0;
      wt_we             = 1'b0;
      wt_re             = 1'b0;
      map_we            = 1'b0;
      gm_waddr          = gm_base + ADDR_W'(cmd_ff.row_index);
      gm_wdata          = GLYPH_BITS'(cmd_ff.row_bits);
      gm_raddr          = gm_base + ADDR_W'(row_ff);
      wt_wdata          = (int'(cmd_ff.glyph_width) > GLYPH_BITS) ?
                          WID_W'(GLYPH_BITS) : WID_W'(cmd_ff.glyph_width);
      rem_sh            = {rem_ff, prod_ff[PROD_W-1]};
      map_num           = up_ff ? PROD_W'(width_ff) : quot_ff;
      map_den           = up_ff ? quot_ff : PROD_W'(width_ff);
      map_sum           = {1'b0, acc_ff} + {1'b0, map_num};
      rsum              = racc_ff + (up_ff ? RW'(height_eff) : RW'(size_eff));
      step              = up_ff ? (rsum >= RW'(size_eff)) : (rsum >= RW'(height_eff));
      last_src          = ((row_ff + 1'b1) == height_eff);
      emit              = step || last_src;

      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (cmd_ff.op)
               OP_LOAD_ROW: begin
                  gm_we = (int'(cmd_ff.row_index) < MAX_GLYPH_ROWS);
               end
               OP_LOAD_WIDTH: begin
                  wt_we = 1'b1;
               end
               OP_SET_CURSOR: begin
                  cur_x_in = cmd_ff.cursor_x;
                  cur_y_in = cmd_ff.cursor_y;
               end
               OP_NEWLINE: begin
                  cur_x_in = 16'd0;
                  cur_y_in = cur_y_ff + 16'(size_eff);
               end
               OP_DRAW: begin
                  wt_re    = 1'b1;
                  state_in = S_WID;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WID: begin
            width_in = wtab_q_ff;
            prod_in  = PROD_W'(size_eff) * PROD_W'(wtab_q_ff);
            rem_in   = '0;
            quot_in  = '0;
            dcnt_in  = DCNT_W'(PROD_W);
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring divide of size * width by height, one bit a cycle
            if (rem_sh >= {1'b0, height_eff}) begin
               rem_in  = HGT_W'(rem_sh - {1'b0, height_eff});
               quot_in = {quot_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[HGT_W-1:0];
               quot_in = {quot_ff[PROD_W-2:0], 1'b0};
            end
            prod_in = prod_ff << 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            cell_in    = (quot_ff > PROD_W'(CELL_LIMIT)) ?
                         CNT_W'(CELL_LIMIT) : CNT_W'(quot_ff);
            up_in      = ({1'b0, size_eff} > (SIZE_W + 1)'(height_eff));
            map_len_in = up_in ? cell_in : CNT_W'(width_ff);
            xcnt_in    = '0;
            idx_in     = '0;
            acc_in     = '0;
            state_in   = S_MAP;
         end
         S_MAP: begin
            if (xcnt_ff == map_len_ff) begin
               row_in   = '0;
               dst_in   = '0;
               racc_in  = '0;
               macc_in  = '0;
               state_in = S_RD;
            end else begin
               map_we  = 1'b1;
               xcnt_in = xcnt_ff + 1'b1;
               if (map_sum >= {1'b0, map_den}) begin
                  acc_in = PROD_W'(map_sum - {1'b0, map_den});
                  idx_in = idx_ff + 1'b1;
               end else begin
                  acc_in = PROD_W'(map_sum);
               end
            end
         end
         S_RD: begin
            gm_re    = 1'b1;
            state_in = S_USE;
         end
         S_USE: begin
            if (up_ff) begin
               if (out_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_row_y_in      = cur_y_ff + 16'(dst_ff);
                  rsp_row_x_in      = cur_x_ff;
                  rsp_cell_width_in = 7'(cell_ff);
                  rsp_fg_mask_in    = up_mask;
                  rsp_fill_bg_in    = !cfg.bg_transparent;
                  rsp_last_row_in   = ((dst_ff + 1'b1) == size_eff);
                  dst_in            = dst_ff + 1'b1;
                  racc_in           = step ? rsum - RW'(size_eff) : rsum;
                  row_in            = step ? row_ff + 1'b1 : row_ff;
                  if ((dst_ff + 1'b1) == size_eff) begin
                     cur_x_in = cur_x_ff + 16'(cell_ff);
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_RD;
                  end
               end
            end else if (!emit || out_free) begin
               if (emit) begin
                  rsp_valid_in      = 1'b1;
                  rsp_row_y_in      = cur_y_ff + 16'(dst_ff);
                  rsp_row_x_in      = cur_x_ff;
                  rsp_cell_width_in = 7'(cell_ff);
                  rsp_fg_mask_in    = new_mask;
                  rsp_fill_bg_in    = !cfg.bg_transparent;
                  rsp_last_row_in   = last_src;
                  macc_in           = '0;
               end else begin
                  macc_in = new_mask;
               end
               dst_in  = step ? dst_ff + 1'b1 : dst_ff;
               racc_in = step ? rsum - RW'(height_eff) : rsum;
               row_in  = row_ff + 1'b1;
               if (last_src) begin
                  cur_x_in = cur_x_ff + 16'(cell_ff);
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_x_ff     <= 16'd0;
         cur_y_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff            <= cmd_in;
      width_ff          <= width_in;
      prod_ff           <= prod_in;
      rem_ff            <= rem_in;
      quot_ff           <= quot_in;
      dcnt_ff           <= dcnt_in;
      cell_ff           <= cell_in;
      map_len_ff        <= map_len_in;
      up_ff             <= up_in;
      xcnt_ff           <= xcnt_in;
      idx_ff            <= idx_in;
      acc_ff            <= acc_in;
      row_ff            <= row_in;
      dst_ff            <= dst_in;
      racc_ff           <= racc_in;
      macc_ff           <= macc_in;
      rsp_row_y_ff      <= rsp_row_y_in;
      rsp_row_x_ff      <= rsp_row_x_in;
      rsp_cell_width_ff <= rsp_cell_width_in;
      rsp_fg_mask_ff    <= rsp_fg_mask_in;
      rsp_fill_bg_ff    <= rsp_fill_bg_in;
      rsp_last_row_ff   <= rsp_last_row_in;
   end

   // column maps, one entry per cycle
   always_ff @(posedge clock) begin
      if (map_we && up_ff) begin
         umap_ff[xcnt_ff[DX_W-1:0]] <= SX_W'(idx_ff);
      end
      if (map_we && !up_ff) begin
         dmap_ff[xcnt_ff[SX_W-1:0]] <= DX_W'(idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (gm_we) begin
         glyph_mem[gm_waddr] <= gm_wdata;
      end
      if (gm_re) begin
         glyph_q_ff <= glyph_mem[gm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wtab_mem[ch_idx] <= wt_wdata;
      end
      if (wt_re) begin
         wtab_q_ff <= wtab_mem[ch_idx];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_y      = rsp_row_y_ff;
   assign rsp_row_x      = rsp_row_x_ff;
   assign rsp_cell_width = rsp_cell_width_ff;
   assign rsp_fg_mask    = rsp_fg_mask_ff;
   assign rsp_fill_bg    = rsp_fill_bg_ff;
   assign rsp_last_row   = rsp_last_row_ff;

endmodule

// File: src/sgr_checker.sv
// Port-level checks on the renderer's result channel, bound to the top level.
`timescale 1ns / 1ps
`include "scaled_glyph_row_renderer_defines.svh"
module sgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_cell_width,
   input logic [63:0] rsp_fg_mask
);

   `SGR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fg_mask), "stalled rsp changed")
   `SGR_ASSERT_IMP(a_rsp_after_reset, $past(reset), !rsp_valid, "rsp valid right after reset")
   `SGR_ASSERT_IMP(a_cell_clamp, rsp_valid, rsp_cell_width <= 7'd64, "cell width above 64")

endmodule

bind scaled_glyph_row_renderer sgr_checker u_sgr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_width (rsp_cell_width),
   .rsp_fg_mask    (rsp_fg_mask)
);

// File: tb/sv/scaled_glyph_row_renderer_tb.sv
// Self-checking testbench for the scaled glyph row renderer: random and directed ops, scoreboard.
`timescale 1ns / 1ps
module scaled_glyph_row_renderer_tb;
   import sgr_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [2:0]  op;
      logic [7:0]  char_code;
      logic [4:0]  row_index;
      logic [31:0] row_bits;
      logic [5:0]  glyph_width;
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
   } glyph_op_type;

   typedef struct {
      logic [15:0] row_y;
      logic [15:0] row_x;
      logic [6:0]  cell_width;
      logic [63:0] fg_mask;
      logic        fill_bg;
      logic        last_row;
   } dest_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [7:0]  req_char_code = '0;
   logic [4:0]  req_row_index = '0;
   logic [31:0] req_row_bits = '0;
   logic [5:0]  req_glyph_width = '0;
   logic [15:0] req_cursor_x = '0;
   logic [15:0] req_cursor_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_row_y;
   logic [15:0] rsp_row_x;
   logic [6:0]  rsp_cell_width;
   logic [63:0] rsp_fg_mask;
   logic        rsp_fill_bg;
   logic        rsp_last_row;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   scaled_glyph_row_renderer u_dut (.*);

   // scoreboard state
   glyph_op_type pending_ops[$];
   glyph_op_type in_flight;
   dest_row_type expected_rows[$];
   logic [31:0] glyph_rows[256][32];
   logic [5:0]  glyph_widths[256];
   logic [6:0]  text_size = TEXT_SIZE_RST;
   logic [5:0]  font_height = FONT_HEIGHT_RST;
   logic        bg_transparent = BG_TRANSPARENT_RST;
   logic [15:0] pen_x = '0;
   logic [15:0] pen_y = '0;

   // generator-side bookkeeping of what has been written
   bit          row_loaded[256][32];
   bit          width_loaded[256];
   logic [7:0]  fav_chars[8];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int cycles = 0;
   int ops_sent = 0;
   int rows_checked = 0;
   int draws_done = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void render_op(glyph_op_type c);
      int sz, ht, wd, ew, cell_w, sx, dx, dy;
      logic [31:0] src;
      logic [63:0] masks[64];
      dest_row_type r;
      sz = (text_size == 0) ? 1 : (text_size > 64) ? 64 : int'(text_size);
      ht = (font_height == 0) ? 1 : (font_height > 32) ? 32 : int'(font_height);
      case (c.op)
         OP_LOAD_ROW: glyph_rows[c.char_code][c.row_index] = c.row_bits;
         OP_LOAD_WIDTH: glyph_widths[c.char_code] = (c.glyph_width > 32) ? 6'd32 : c.glyph_width;
         OP_SET_CURSOR: begin
            pen_x = c.cursor_x;
            pen_y = c.cursor_y;
         end
         OP_NEWLINE: begin
            pen_x = '0;
            pen_y = pen_y + 16'(sz);
         end
         OP_DRAW: begin
            wd = int'(glyph_widths[c.char_code]);
            ew = sz * wd / ht;
            cell_w = (ew > 64) ? 64 : ew;
            for (int y = 0; y < 64; y++) masks[y] = '0;
            if (sz > ht) begin
               for (int y = 0; y < sz; y++) begin
                  src = glyph_rows[c.char_code][y * ht / sz];
                  for (int x = 0; x < cell_w; x++) begin
                     sx = x * wd / ew;
                     if (src[sx]) masks[y][x] = 1'b1;
                  end
               end
            end else begin
               for (int y = 0; y < ht; y++) begin
                  src = glyph_rows[c.char_code][y];
                  dy = y * sz / ht;
                  for (int x = 0; x < wd; x++) begin
                     if (src[x]) begin
                        dx = x * ew / wd;
                        if (dx < 64 && dy < 64) masks[dy][dx] = 1'b1;
                     end
                  end
               end
            end
            for (int y = 0; y < sz; y++) begin
               r.row_y = pen_y + 16'(y);
               r.row_x = pen_x;
               r.cell_width = 7'(cell_w);
               r.fg_mask = masks[y];
               r.fill_bg = ~bg_transparent;
               r.last_row = (y + 1 == sz);
               expected_rows.push_back(r);
            end
            pen_x = pen_x + 16'(cell_w);
            draws_done++;
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            render_op(in_flight);
            ops_sent++;
         end
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            in_flight = pending_ops.pop_front();
            req_op <= in_flight.op;
            req_char_code <= in_flight.char_code;
            req_row_index <= in_flight.row_index;
            req_row_bits <= in_flight.row_bits;
            req_glyph_width <= in_flight.glyph_width;
            req_cursor_x <= in_flight.cursor_x;
            req_cursor_y <= in_flight.cursor_y;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      dest_row_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               $error("unexpected result row: row_y %0d row_x %0d", rsp_row_y, rsp_row_x);
               errors++;
            end else begin
               e = expected_rows.pop_front();
               rows_checked++;
               if (rsp_row_y !== e.row_y) begin
                  $error("row_y: expected %0d, got %0d", e.row_y, rsp_row_y);
                  errors++;
               end
               if (rsp_row_x !== e.row_x) begin
                  $error("row_x: expected %0d, got %0d", e.row_x, rsp_row_x);
                  errors++;
               end
               if (rsp_cell_width !== e.cell_width) begin
                  $error("cell_width: expected %0d, got %0d", e.cell_width, rsp_cell_width);
                  errors++;
               end
               if (rsp_fg_mask !== e.fg_mask) begin
                  $error("fg_mask: expected %h, got %h", e.fg_mask, rsp_fg_mask);
                  errors++;
               end
               if (rsp_fill_bg !== e.fill_bg) begin
                  $error("fill_bg: expected %b, got %b", e.fill_bg, rsp_fill_bg);
                  errors++;
               end
               if (rsp_last_row !== e.last_row) begin
                  $error("last_row: expected %b, got %b", e.last_row, rsp_last_row);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic glyph_op_type mk_op(logic [2:0] op, logic [7:0] ch);
      glyph_op_type c;
      c.op = op;
      c.char_code = ch;
      c.row_index = 5'($urandom_range(0, 31));
      c.row_bits = $urandom;
      c.glyph_width = 6'($urandom_range(0, 63));
      c.cursor_x = 16'($urandom);
      c.cursor_y = 16'($urandom);
      return c;
   endfunction

   task automatic queue_op(glyph_op_type c);
      if (c.op == OP_LOAD_ROW) row_loaded[c.char_code][c.row_index] = 1'b1;
      if (c.op == OP_LOAD_WIDTH) width_loaded[c.char_code] = 1'b1;
      pending_ops.push_back(c);
   endtask

   // loads any glyph data still missing, then draws
   task automatic queue_draw(logic [7:0] ch);
      glyph_op_type c;
      for (int r = 0; r < 32; r++) begin
         if (!row_loaded[ch][r]) begin
            c = mk_op(OP_LOAD_ROW, ch);
            c.row_index = 5'(r);
            queue_op(c);
         end
      end
      if (!width_loaded[ch]) queue_op(mk_op(OP_LOAD_WIDTH, ch));
      queue_op(mk_op(OP_DRAW, ch));
   endtask

   task automatic queue_random(int n);
      int r;
      logic [7:0] ch;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : fav_chars[$urandom_range(0, 7)];
         if (r < 40) queue_draw(fav_chars[$urandom_range(0, 7)]);
         else if (r < 58) queue_op(mk_op(OP_LOAD_ROW, ch));
         else if (r < 68) queue_op(mk_op(OP_LOAD_WIDTH, ch));
         else if (r < 78) queue_op(mk_op(OP_SET_CURSOR, ch));
         else if (r < 88) queue_op(mk_op(OP_NEWLINE, ch));
         else if (r < 94) queue_op(mk_op(3'($urandom_range(5, 7)), ch));
         else queue_op(mk_op(OP_LOAD_ROW, fav_chars[$urandom_range(0, 7)]));
      end
   endtask

   task automatic wait_idle();
      while (pending_ops.size() != 0 || req_valid || expected_rows.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [6:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEXT_SIZE: text_size = value;
         CSR_FONT_HEIGHT: font_height = value[5:0];
         CSR_BG_TRANSPARENT: bg_transparent = value[0];
         default: ;
      endcase
   endtask

   task automatic set_mode(int m);
      case (m % 4)
         0: begin send_idle_pct = 0; stall_pct = 0; end
         1: begin send_idle_pct = 63; stall_pct = 0; end
         2: begin send_idle_pct = 0; stall_pct = 63; end
         default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
   endtask

   initial begin
      glyph_op_type c;
      logic [6:0] cfg_size[7];
      logic [6:0] cfg_height[7];
      logic [7:0] fav_a;
      logic [7:0] fav_b;
      cfg_size = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd17, 7'd3, 7'd40};
      cfg_height = '{7'd32, 7'd1, 7'd0, 7'd63, 7'd5, 7'd8, 7'd12};
      fav_a = 8'($urandom);
      fav_b = 8'($urandom);
      fav_chars[0] = 8'h00;
      fav_chars[1] = 8'hFF;
      for (int i = 2; i < 8; i++) fav_chars[i] = (i % 2 == 0) ? fav_a : fav_b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default config, extremes, every op, width corner cases
      c = mk_op(OP_SET_CURSOR, 8'h00);
      c.cursor_x = 16'hFFFF;
      c.cursor_y = 16'hFFFC;
      queue_op(c);
      for (int r = 0; r < 32; r++) begin
         c = mk_op(OP_LOAD_ROW, 8'hFF);
         c.row_index = 5'(r);
         c.row_bits = (r % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
         queue_op(c);
      end
      c = mk_op(OP_LOAD_WIDTH, 8'hFF);
      c.glyph_width = 6'd63;
      queue_op(c);
      queue_draw(8'hFF);
      queue_op(mk_op(OP_NEWLINE, 8'h00));
      queue_op(mk_op(3'd7, 8'hFF));
      c = mk_op(OP_LOAD_WIDTH, 8'h00);
      c.glyph_width = 6'd0;
      queue_op(c);
      queue_draw(8'h00);
      c = mk_op(OP_LOAD_WIDTH, 8'h00);
      c.glyph_width = 6'd1;
      queue_op(c);
      queue_draw(8'h00);
      queue_random(10);
      wait_idle();

      for (int p = 0; p < 7; p++) begin
         write_csr(CSR_TEXT_SIZE, cfg_size[p]);
         write_csr(CSR_FONT_HEIGHT, cfg_height[p]);
         write_csr(CSR_BG_TRANSPARENT, 7'(p % 2));
         set_mode(p + 1);
         queue_random(10);
         if (p == 2) begin
            // sender holds off until the block has drained
            while (pending_ops.size() != 0 || req_valid || expected_rows.size() != 0)
               @(posedge clock);
         end
         queue_random(10);
         wait_idle();
      end
      write_csr(CSR_TEXT_SIZE, 7'd8);
      write_csr(CSR_FONT_HEIGHT, 7'd8);
      write_csr(CSR_BG_TRANSPARENT, 7'd1);
      set_mode(3);
      queue_random(10);
      wait_idle();

      $display("ran %0d ops (%0d draws) over 9 register settings, checked %0d result rows",
               ops_sent, draws_done, rows_checked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/sgr_pkg.sv
src/sgr_front.sv
src/sgr_back.sv
src/scaled_glyph_row_renderer.sv
src/sgr_checker.sv
tb/sv/scaled_glyph_row_renderer_tb.sv
